// ===== src/hsv2rgb_pkg.sv =====
`timescale 1ns / 1ps
package hsv2rgb_pkg;

  localparam int HUE_W  = 32;
  localparam int CH_W   = 8;
  localparam int OUT_CH = 5;
  localparam int OUT_W  = 3 * OUT_CH;

  localparam logic [CH_W-1:0] CH_FULL = 8'd255;

  // Hue high part: arithmetic hue >> 9, taken apart into 2-bit digits
  localparam int HUE_LO_W = 9;
  localparam int HI_W     = HUE_W - HUE_LO_W;
  localparam int HI_DIG   = (HI_W + 1) / 2;

  typedef enum logic [2:0] {
    SEXT_RED_YEL  = 3'd0,
    SEXT_YEL_GRN  = 3'd1,
    SEXT_GRN_CYN  = 3'd2,
    SEXT_CYN_BLU  = 3'd3,
    SEXT_BLU_MAG  = 3'd4,
    SEXT_MAG_RED  = 3'd5
  } sextant_t;

  typedef struct packed {
    logic [CH_W-1:0]  bri;
    logic [CH_W-1:0]  sat;
    logic [HUE_W-1:0] hue;
  } hsv_t;

  typedef struct packed {
    logic [CH_W-1:0]     bri;
    logic [CH_W-1:0]     sat;
    logic                neg;
    logic [5:0]          dsum;
    logic [HUE_LO_W-1:0] lo9;
  } hue_part_t;

  typedef struct packed {
    logic [CH_W-1:0] b;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] r;
  } rgb_t;

  typedef struct packed {
    logic [CH_W-1:0] bri;
    logic [CH_W-1:0] sat;
    rgb_t            rgb;
  } pix_t;

  typedef struct packed {
    logic [CH_W-1:0] bri;
    rgb_t            rgb;
  } tint_t;

  // x mod 3 for x <= 63, by folding base-4 digits (4 = 1 mod 3)
  function automatic logic [1:0] mod3_6b(input logic [5:0] x);
    logic [3:0] s1;
    logic [2:0] s2;
    s1 = {2'b00, x[5:4]} + {2'b00, x[3:2]} + {2'b00, x[1:0]};
    s2 = {1'b0, s1[3:2]} + {1'b0, s1[1:0]};
    if (s2 >= 3'd3) begin
      s2 = s2 - 3'd3;
    end
    return s2[1:0];
  endfunction

  function automatic logic [OUT_CH-1:0] rev5(input logic [OUT_CH-1:0] v);
    logic [OUT_CH-1:0] r;
    for (int i = 0; i < OUT_CH; i++) begin
      r[i] = v[OUT_CH-1-i];
    end
    return r;
  endfunction

endpackage

// ===== src/hsv2rgb_hue.sv =====
`timescale 1ns / 1ps
// Two stages: digit sum of the high hue bits, then mod 1536 and sextant mix.
module hsv2rgb_hue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               i_valid,
  output logic               i_ready,
  input  hsv2rgb_pkg::hsv_t  i_hsv,
  output logic               o_valid,
  input  logic               o_ready,
  output hsv2rgb_pkg::pix_t  o_pix
);
  import hsv2rgb_pkg::*;

  logic      s1_valid_r;
  hue_part_t s1_r;
  hue_part_t s1_nxt;
  logic      s1_ready;
  logic      s2_valid_r;
  pix_t      s2_r;
  pix_t      s2_nxt;
  logic      s2_ready;

  assign s2_ready = !s2_valid_r || o_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign i_ready  = s1_ready;
  assign o_valid  = s2_valid_r;
  assign o_pix    = s2_r;

  // stage 1: hue = hi*512 + lo9, hi mod 3 from base-4 digit sum of hi
  always_comb begin
    logic [2*HI_DIG-1:0] hz;
    logic [2:0]          ps [HI_DIG/2];
    logic [5:0]          acc;
    hz  = {{(2*HI_DIG-HI_W){1'b0}}, i_hsv.hue[HUE_W-1:HUE_LO_W]};
    acc = '0;
    for (int k = 0; k < HI_DIG/2; k++) begin
      ps[k] = {1'b0, hz[4*k+3 -: 2]} + {1'b0, hz[4*k+1 -: 2]};
    end
    for (int k = 0; k < HI_DIG/2; k++) begin
      acc = acc + {3'b000, ps[k]};
    end
    s1_nxt.bri  = i_hsv.bri;
    s1_nxt.sat  = i_hsv.sat;
    s1_nxt.neg  = i_hsv.hue[HUE_W-1];
    s1_nxt.dsum = acc;
    s1_nxt.lo9  = i_hsv.hue[HUE_LO_W-1:0];
  end

  // stage 2: two's complement high part adds 2^23 = 2 mod 3, so add sign back
  always_comb begin
    logic [1:0]      m3;
    logic [CH_W-1:0] lo;
    sextant_t        sx;
    m3 = mod3_6b(s1_r.dsum + {5'd0, s1_r.neg});
    lo = s1_r.lo9[CH_W-1:0];
    sx = sextant_t'({m3, s1_r.lo9[HUE_LO_W-1]});
    s2_nxt.bri = s1_r.bri;
    s2_nxt.sat = s1_r.sat;
    case (sx)
      SEXT_RED_YEL: s2_nxt.rgb = '{b: '0,           g: lo,           r: CH_FULL};
      SEXT_YEL_GRN: s2_nxt.rgb = '{b: '0,           g: CH_FULL,      r: CH_FULL - lo};
      SEXT_GRN_CYN: s2_nxt.rgb = '{b: lo,           g: CH_FULL,      r: '0};
      SEXT_CYN_BLU: s2_nxt.rgb = '{b: CH_FULL,      g: CH_FULL - lo, r: '0};
      SEXT_BLU_MAG: s2_nxt.rgb = '{b: CH_FULL,      g: '0,           r: lo};
      default:      s2_nxt.rgb = '{b: CH_FULL - lo, g: '0,           r: CH_FULL};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= i_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && i_valid) begin
      s1_r <= s1_nxt;
    end
    if (s2_ready && s1_valid_r) begin
      s2_r <= s2_nxt;
    end
  end

endmodule

// ===== src/hsv2rgb_tint.sv =====
`timescale 1ns / 1ps
// Saturation stage: c = 255 - (((255 - c) * (sat + 1)) >> 8)
module hsv2rgb_tint (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               i_valid,
  output logic               i_ready,
  input  hsv2rgb_pkg::pix_t  i_pix,
  output logic               o_valid,
  input  logic               o_ready,
  output hsv2rgb_pkg::tint_t o_tint
);
  import hsv2rgb_pkg::*;

  logic  valid_r;
  tint_t tint_r;
  tint_t tint_nxt;

  function automatic logic [CH_W-1:0] to_white(input logic [CH_W-1:0] c,
                                              input logic [CH_W:0]   s1);
    logic [2*CH_W:0] p;
    p = {{(CH_W+1){1'b0}}, CH_FULL - c} * {{CH_W{1'b0}}, s1};
    return CH_FULL - p[2*CH_W-1:CH_W];
  endfunction

  always_comb begin
    logic [CH_W:0] s1;
    s1 = {1'b0, i_pix.sat} + 9'd1;
    tint_nxt.bri   = i_pix.bri;
    tint_nxt.rgb.r = to_white(i_pix.rgb.r, s1);
    tint_nxt.rgb.g = to_white(i_pix.rgb.g, s1);
    tint_nxt.rgb.b = to_white(i_pix.rgb.b, s1);
  end

  assign i_ready = !valid_r || o_ready;
  assign o_valid = valid_r;
  assign o_tint  = tint_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (i_ready) begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (i_ready && i_valid) begin
      tint_r <= tint_nxt;
    end
  end

endmodule

// ===== src/hsv2rgb_shade.sv =====
`timescale 1ns / 1ps
// Value stage and output register: (c * (bri + 1)) >> 11, reversed, packed
module hsv2rgb_shade (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               i_valid,
  output logic                               i_ready,
  input  hsv2rgb_pkg::tint_t                 i_tint,
  output logic                               o_valid,
  input  logic                               o_ready,
  output logic [hsv2rgb_pkg::OUT_W-1:0]      o_color
);
  import hsv2rgb_pkg::*;

  logic             valid_r;
  logic [OUT_W-1:0] color_r;
  logic [OUT_W-1:0] color_nxt;

  function automatic logic [OUT_CH-1:0] shade5(input logic [CH_W-1:0] c,
                                              input logic [CH_W:0]   v1);
    logic [2*CH_W:0] q;
    q = {{(CH_W+1){1'b0}}, c} * {{CH_W{1'b0}}, v1};
    return q[2*CH_W-1 -: OUT_CH];
  endfunction

  always_comb begin
    logic [CH_W:0] v1;
    v1 = {1'b0, i_tint.bri} + 9'd1;
    color_nxt = {rev5(shade5(i_tint.rgb.b, v1)),
                 rev5(shade5(i_tint.rgb.g, v1)),
                 rev5(shade5(i_tint.rgb.r, v1))};
  end

  assign i_ready = !valid_r || o_ready;
  assign o_valid = valid_r;
  assign o_color = color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (i_ready) begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (i_ready && i_valid) begin
      color_r <= color_nxt;
    end
  end

endmodule

// ===== src/hsv_to_rgb555_reversed_unit.sv =====
`timescale 1ns / 1ps
// HSV to RGB555 converter with bit-reversed channels. Takes one request per
// clock while the output side is not stalled and returns one 15-bit color
// word per request. A request passes through four register stages: hue
// reduction (digit sum), sextant/primary mix, saturation blend toward white,
// and value scaling into the output register.
// Each stage has its own valid bit and holds while the one after it is full
// and stalled, so bubbles close up and nothing is dropped or duplicated. The
// hue is signed and wraps every 1536 steps (-1 maps to 1535). Red lands in
// bits 4:0, green in 9:5, blue in 14:10, each 5-bit field bit-reversed.
// There is no state between requests and no configuration.
module hsv_to_rgb555_reversed_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [31:0] hue_angle, [39:32] saturation, [47:40] brightness
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [14:0] packed_color, [15] zero
);
  import hsv2rgb_pkg::*;

  hsv_t             hsv;
  logic             hue_valid;
  logic             hue_ready;
  pix_t             hue_pix;
  logic             tint_valid;
  logic             tint_ready;
  tint_t            tint;
  logic [OUT_W-1:0] color;

  assign hsv.hue = in_tdata[HUE_W-1:0];
  assign hsv.sat = in_tdata[HUE_W+CH_W-1:HUE_W];
  assign hsv.bri = in_tdata[HUE_W+2*CH_W-1:HUE_W+CH_W];

  hsv2rgb_hue u_hue (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (in_tvalid),
    .i_ready (in_tready),
    .i_hsv   (hsv),
    .o_valid (hue_valid),
    .o_ready (hue_ready),
    .o_pix   (hue_pix)
  );

  hsv2rgb_tint u_tint (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (hue_valid),
    .i_ready (hue_ready),
    .i_pix   (hue_pix),
    .o_valid (tint_valid),
    .o_ready (tint_ready),
    .o_tint  (tint)
  );

  hsv2rgb_shade u_shade (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (tint_valid),
    .i_ready (tint_ready),
    .i_tint  (tint),
    .o_valid (out_tvalid),
    .o_ready (out_tready),
    .o_color (color)
  );

  assign out_tdata = {1'b0, color};

  // a draining output must never back-pressure the input
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output drains");

  // with the hue, tint and output stages empty, the tint and shade stages are always ready
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!hue_valid && !tint_valid && !out_tvalid) |-> (hue_ready && tint_ready))
    else $error("empty pipe not ready");

  // a mid-pipe item with room ahead reaches the output register in the next cycle
  a_tint_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (tint_valid && tint_ready) |=> out_tvalid)
    else $error("tint stage item lost");

endmodule
